@@ rtl/esar_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esar_pkg
// Shared widths, codes and types for the event slice accumulate-and-read block.
// ----------------------------------------------------------------------------
package esar_pkg;

  localparam int SLICE_COUNT     = 4;
  localparam int SLICE_W         = 2;
  localparam int PIXELS_PER_WORD = 16;
  localparam int PIX_W           = 4;
  localparam int WORD_W          = PIXELS_PER_WORD * PIX_W;
  localparam int COORD_W         = 8;
  localparam int WROW_W          = 5;
  localparam int EVENT_WORD_W    = 17;

  typedef logic [PIX_W-1:0]        pix_t;
  typedef logic [COORD_W-1:0]      coord_t;
  typedef logic [WROW_W-1:0]       wrow_t;
  typedef logic [EVENT_WORD_W-1:0] event_word_t;
  typedef logic [SLICE_W-1:0]      slice_t;

  // input opcodes
  localparam logic OP_EVENT   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

endpackage

@@ rtl/event_slice_accumulate_and_read_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_slice_accumulate_and_read_top
// Rotating four-slice event count store with a windowed column read per event.
// ----------------------------------------------------------------------------
// After reset the block sweeps its store to zero, one 64-bit word per cycle,
// over 4 * 2^ceil(log2(SLICE_COLUMNS)) * 2^ceil(log2(SLICE_ROWS/16)) words
// (16384 at the default sizes), with in_ready low throughout. An advance
// transaction gives no result. A pixel event, once accepted, reads the
// active-slice word (while the stale word in slice active+3 is cleared),
// writes back the incremented count, then reads BLOCK_SIDE + 2*SEARCH_RADIUS
// window rows (17 at defaults) and moves the last row from the RAM read
// register to the output before the next transaction can be accepted. Each
// window row costs one read on each of the two store read ports (one for the
// reference slice, one for the target slice). Results leave through an
// output register; a stalled result does not lose the read data, which waits
// in the RAM read register until the output frees up.
// ----------------------------------------------------------------------------
module event_slice_accumulate_and_read_top #(
  parameter int SLICE_COLUMNS = 256,
  parameter int SLICE_ROWS    = 256,
  parameter int BLOCK_SIDE    = 5,
  parameter int SEARCH_RADIUS = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_opcode,
  input  esar_pkg::coord_t     in_event_x,
  input  esar_pkg::coord_t     in_event_y,
  input  logic                 in_polarity,
  output logic                 out_valid,
  input  logic                 out_ready,
  output esar_pkg::pix_t       out_ref_pixel,
  output esar_pkg::pix_t       out_tag_pixel,
  output esar_pkg::wrow_t      out_window_row,
  output esar_pkg::event_word_t out_event_word,
  output logic                 out_last
);

  import esar_pkg::*;

  // store layout: {slice, column, word-in-column}, padded to powers of two
  localparam int COL_B   = $clog2(SLICE_COLUMNS);
  localparam int WPC     = (SLICE_ROWS + PIXELS_PER_WORD - 1) / PIXELS_PER_WORD;
  localparam int WRD_B   = $clog2(WPC);
  localparam int AW      = SLICE_W + COL_B + WRD_B;
  localparam int DEPTH   = 1 << AW;
  localparam int WIN_LEN = BLOCK_SIDE + 2 * SEARCH_RADIUS;

  localparam logic [COORD_W:0]   COL_LIM    = (COORD_W+1)'(SLICE_COLUMNS);
  localparam logic [COORD_W:0]   ROW_LIM    = (COORD_W+1)'(SLICE_ROWS);
  localparam logic [COORD_W-1:0] WIN_OFFSET = COORD_W'(BLOCK_SIDE / 2 + SEARCH_RADIUS);
  localparam wrow_t              WIN_LAST   = WROW_W'(WIN_LEN - 1);

  // sequencer codes
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_INC_RD = 3'd1;
  localparam logic [2:0] ST_INC_WR = 3'd2;
  localparam logic [2:0] ST_WIN    = 3'd3;

  logic [2:0]        state_r, state_nxt;
  logic              clearing_r, clearing_nxt;
  logic [AW-1:0]     clr_cnt_r, clr_cnt_nxt;
  slice_t            act_r, act_nxt;

  // latched event
  coord_t            ev_x_r, ev_y_r;
  logic              ev_pol_r;

  // window walk
  wrow_t             win_idx_r, win_idx_nxt;
  logic              dv_r, dv_nxt;      // RAM read registers hold unconsumed rows
  wrow_t             meta_row_r;
  logic              meta_last_r;
  logic              meta_zero_r;
  logic [3:0]        meta_nib_r;

  // output register
  logic              out_valid_r, out_valid_nxt;
  pix_t              out_ref_r, out_tag_r;
  wrow_t             out_row_r;
  event_word_t       out_word_r;
  logic              out_last_r;

  // RAM ports
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re_a, ram_re_b;
  logic [AW-1:0]     ram_raddr_a, ram_raddr_b;
  logic [WORD_W-1:0] ram_rdata_a, ram_rdata_b;

  logic              in_acc, x_ok, xy_ok;
  logic              load, issue;
  logic [COORD_W-1:0] win_start;
  logic [COORD_W:0]  win_rowc;
  logic              row_ok;
  slice_t            ref_s, tag_s, clr_s;
  logic [AW-1:0]     act_addr, clr_addr;
  logic [COL_B-1:0]  x_col;
  logic [WRD_B-1:0]  y_wrd, r_wrd;
  logic [WORD_W-1:0] inc_word;

  assign in_ready = (state_r == ST_IDLE) && !clearing_r && !dv_r;
  assign in_acc   = in_valid && in_ready;

  assign ref_s = act_r + SLICE_W'(1);
  assign tag_s = act_r + SLICE_W'(2);
  assign clr_s = act_r + SLICE_W'(3);

  assign x_ok  = {1'b0, ev_x_r} < COL_LIM;
  assign xy_ok = x_ok && ({1'b0, ev_y_r} < ROW_LIM);

  assign x_col    = ev_x_r[COL_B-1:0];
  assign y_wrd    = ev_y_r[WRD_B+3:4];
  assign act_addr = {act_r, x_col, y_wrd};
  assign clr_addr = {clr_s, x_col, y_wrd};

  // current window row; rows past the column top read as zero
  assign win_start = ev_y_r - WIN_OFFSET;
  assign win_rowc  = {1'b0, win_start} + (COORD_W+1)'(win_idx_r);
  assign row_ok    = x_ok && (win_rowc < ROW_LIM);
  assign r_wrd     = win_rowc[WRD_B+3:4];

  // results move on from the RAM read register when the output has room
  assign load  = dv_r && (!out_valid_r || out_ready);
  assign issue = (state_r == ST_WIN) && (!dv_r || load);

  // count increment, wraps at four bits
  always_comb begin
    inc_word = ram_rdata_a;
    inc_word[{ev_y_r[3:0], 2'b00} +: PIX_W] =
      ram_rdata_a[{ev_y_r[3:0], 2'b00} +: PIX_W] + PIX_W'(1);
  end

  // store port steering
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = clr_cnt_r;
    ram_wdata   = '0;
    ram_re_a    = 1'b0;
    ram_raddr_a = act_addr;
    ram_re_b    = 1'b0;
    ram_raddr_b = {tag_s, x_col, r_wrd};
    if (clearing_r) begin
      ram_we = 1'b1;
    end else begin
      unique case (state_r)
        ST_INC_RD: begin
          ram_re_a  = 1'b1;
          ram_we    = xy_ok;
          ram_waddr = clr_addr;
        end
        ST_INC_WR: begin
          ram_we    = xy_ok;
          ram_waddr = act_addr;
          ram_wdata = inc_word;
        end
        ST_WIN: begin
          ram_re_a    = issue;
          ram_raddr_a = {ref_s, x_col, r_wrd};
          ram_re_b    = issue;
        end
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    act_nxt      = act_r;
    win_idx_nxt  = win_idx_r;
    clearing_nxt = clearing_r;
    clr_cnt_nxt  = clr_cnt_r;
    if (clearing_r) begin
      clr_cnt_nxt = clr_cnt_r + AW'(1);
      if (clr_cnt_r == {AW{1'b1}}) begin
        clearing_nxt = 1'b0;
      end
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_opcode == OP_ADVANCE) begin
            act_nxt = act_r + SLICE_W'(1);
          end else begin
            state_nxt = ST_INC_RD;
          end
        end
      end
      ST_INC_RD: state_nxt = ST_INC_WR;
      ST_INC_WR: begin
        state_nxt   = ST_WIN;
        win_idx_nxt = '0;
      end
      ST_WIN: begin
        if (issue) begin
          win_idx_nxt = win_idx_r + WROW_W'(1);
          if (win_idx_r == WIN_LAST) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    dv_nxt = dv_r;
    if (issue) begin
      dv_nxt = 1'b1;
    end else if (load) begin
      dv_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      clearing_r  <= 1'b1;
      clr_cnt_r   <= '0;
      act_r       <= '0;
      win_idx_r   <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clearing_r  <= clearing_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      act_r       <= act_nxt;
      win_idx_r   <= win_idx_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ev_x_r   <= in_event_x;
      ev_y_r   <= in_event_y;
      ev_pol_r <= in_polarity;
    end
    if (issue) begin
      meta_row_r  <= win_idx_r;
      meta_last_r <= (win_idx_r == WIN_LAST);
      meta_zero_r <= !row_ok;
      meta_nib_r  <= win_rowc[3:0];
    end
    if (load) begin
      out_ref_r  <= meta_zero_r ? '0 : ram_rdata_a[{meta_nib_r, 2'b00} +: PIX_W];
      out_tag_r  <= meta_zero_r ? '0 : ram_rdata_b[{meta_nib_r, 2'b00} +: PIX_W];
      out_row_r  <= meta_row_r;
      out_last_r <= meta_last_r;
      out_word_r <= {ev_pol_r, ev_y_r, ev_x_r};
    end
  end

  esar_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re_a    (ram_re_a),
    .raddr_a (ram_raddr_a),
    .rdata_a (ram_rdata_a),
    .re_b    (ram_re_b),
    .raddr_b (ram_raddr_b),
    .rdata_b (ram_rdata_b)
  );

  assign out_valid      = out_valid_r;
  assign out_ref_pixel  = out_ref_r;
  assign out_tag_pixel  = out_tag_r;
  assign out_window_row = out_row_r;
  assign out_event_word = out_word_r;
  assign out_last       = out_last_r;

endmodule

@@ rtl/esar_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esar_ram
// Generic RAM: one write port, two read ports, registered read data that
// holds while its read enable is low.
// ----------------------------------------------------------------------------
module esar_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic                     re_b,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

@@ rtl/esar_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esar_checker
// Port-level checks for the event slice accumulate-and-read block.
// ----------------------------------------------------------------------------
module esar_checker #(
  parameter int BLOCK_SIDE    = 5,
  parameter int SEARCH_RADIUS = 6
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  in_opcode,
  input logic                  out_valid,
  input logic                  out_ready,
  input esar_pkg::pix_t        out_ref_pixel,
  input esar_pkg::pix_t        out_tag_pixel,
  input esar_pkg::wrow_t       out_window_row,
  input esar_pkg::event_word_t out_event_word,
  input logic                  out_last
);

  import esar_pkg::*;

  localparam wrow_t WIN_LAST = WROW_W'(BLOCK_SIDE + 2 * SEARCH_RADIUS - 1);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ref_pixel) &&
      $stable(out_tag_pixel) && $stable(out_window_row) && $stable(out_event_word))
    else $error("result changed while stalled");

  // last flag marks exactly the final window row, and rows stay in the window
  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_window_row == WIN_LAST)) && (out_window_row <= WIN_LAST))
    else $error("window row / last mismatch");

  // a pixel event keeps the input side busy for its read-modify-write
  a_event_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_opcode == OP_EVENT) |=> !in_ready)
    else $error("input accepted during event update");

  // reset starts the store sweep with nothing on either side
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("block active straight after reset");

endmodule

bind event_slice_accumulate_and_read_top esar_checker #(
  .BLOCK_SIDE    (BLOCK_SIDE),
  .SEARCH_RADIUS (SEARCH_RADIUS)
) u_esar_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_opcode      (in_opcode),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_ref_pixel  (out_ref_pixel),
  .out_tag_pixel  (out_tag_pixel),
  .out_window_row (out_window_row),
  .out_event_word (out_event_word),
  .out_last       (out_last)
);

@@ tb/sv/event_slice_accumulate_and_read_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_slice_accumulate_and_read_top_tb
// Self-checking bench for the rotating event slice store and its window read.
// ----------------------------------------------------------------------------
// Pixel events and slice advances go in through the input handshake. A shadow
// copy of the four count slices and of the active slice index predicts every
// window row, and each row that leaves the result channel is checked against
// it field by field. The block is built with fewer columns and rows than the
// coordinate range, so events outside the store can be reached.
// ----------------------------------------------------------------------------
module event_slice_accumulate_and_read_top_tb;
  import esar_pkg::*;

  // Reduced store: x >= 192 and y >= 224 fall outside it
  localparam int COLUMNS          = 192;
  localparam int ROWS             = 224;
  localparam int BLOCK_SIDE       = 5;
  localparam int SEARCH_RADIUS    = 6;
  localparam int WINDOW_LEN       = BLOCK_SIDE + 2 * SEARCH_RADIUS;
  localparam int WINDOW_BACKOFF   = BLOCK_SIDE / 2 + SEARCH_RADIUS;
  localparam int WORDS_PER_COLUMN = ROWS / PIXELS_PER_WORD;
  // Longest quiet stretch is the clearing sweep after reset over 4 * 256 * 16 store words
  localparam int STALL_LIMIT      = 60000;
  localparam int DRAIN_CYCLES     = 40;

  typedef struct {
    pix_t        ref_pixel;
    pix_t        tag_pixel;
    wrow_t       window_row;
    event_word_t event_word;
    logic        last;
  } window_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_opcode;
  coord_t      in_event_x;
  coord_t      in_event_y;
  logic        in_polarity;
  logic        out_valid;
  logic        out_ready;
  pix_t        out_ref_pixel;
  pix_t        out_tag_pixel;
  wrow_t       out_window_row;
  event_word_t out_event_word;
  logic        out_last;

  // Shadow of the block state; the store is all zero after reset
  bit [WORD_W-1:0] count_words [SLICE_COUNT][COLUMNS][WORDS_PER_COLUMN];
  slice_t          active_slice = '0;
  window_row_t     pending_rows[$];

  int send_idle_pct   = 33;
  int recv_idle_pct   = 62;
  int error_count     = 0;
  int events_sent     = 0;
  int advances_sent   = 0;
  int rows_checked    = 0;
  int count_wraps     = 0;
  int quiet_cycles    = 0;

  event_slice_accumulate_and_read_top #(
    .SLICE_COLUMNS(COLUMNS),
    .SLICE_ROWS(ROWS),
    .BLOCK_SIDE(BLOCK_SIDE),
    .SEARCH_RADIUS(SEARCH_RADIUS)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_opcode(in_opcode),
    .in_event_x(in_event_x),
    .in_event_y(in_event_y),
    .in_polarity(in_polarity),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_ref_pixel(out_ref_pixel),
    .out_tag_pixel(out_tag_pixel),
    .out_window_row(out_window_row),
    .out_event_word(out_event_word),
    .out_last(out_last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Shadow store
  // --------------------------------------------------------------------------

  // Anything outside the store reads as zero, including rows past the column top
  function automatic pix_t pixel_count(slice_t s, int x, int row);
    if (x >= COLUMNS || row >= ROWS) return '0;
    return count_words[s][x][row / PIXELS_PER_WORD][PIX_W * (row % PIXELS_PER_WORD) +: PIX_W];
  endfunction

  // Applies one accepted transaction to the shadow and queues its window rows
  function automatic void update_slices_and_predict_window(logic op, coord_t x, coord_t y,
                                                            logic pol);
    slice_t      ref_slice;
    slice_t      tag_slice;
    slice_t      stale_slice;
    coord_t      start_row;
    pix_t        new_count;
    window_row_t row_item;
    int          word_idx;
    int          bit_idx;
    if (op == OP_ADVANCE) begin
      active_slice = active_slice + 1'b1;
      return;
    end
    ref_slice   = active_slice + 2'd1;
    tag_slice   = active_slice + 2'd2;
    stale_slice = active_slice + 2'd3;
    // Four distinct slices, so the update order against the reads is immaterial
    if (x < COLUMNS && y < ROWS) begin
      word_idx  = y / PIXELS_PER_WORD;
      bit_idx   = PIX_W * (y % PIXELS_PER_WORD);
      new_count = count_words[active_slice][x][word_idx][bit_idx +: PIX_W] + 1'b1;
      if (new_count == '0) count_wraps++;
      count_words[active_slice][x][word_idx][bit_idx +: PIX_W] = new_count;
      count_words[stale_slice][x][word_idx] = '0;
    end
    start_row = y - coord_t'(WINDOW_BACKOFF);  // wraps modulo 256
    for (int i = 0; i < WINDOW_LEN; i++) begin
      row_item.ref_pixel  = pixel_count(ref_slice, x, int'(start_row) + i);
      row_item.tag_pixel  = pixel_count(tag_slice, x, int'(start_row) + i);
      row_item.window_row = wrow_t'(i);
      row_item.event_word = {pol, y, x};
      row_item.last       = (i == WINDOW_LEN - 1);
      pending_rows.push_back(row_item);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Drives one transaction at the falling edge, holds it until accepted
  task automatic send_transaction(logic op, coord_t x, coord_t y, logic pol);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_opcode   <= op;
    in_event_x  <= x;
    in_event_y  <= y;
    in_polarity <= pol;
    do @(posedge clk); while (!in_ready);
    update_slices_and_predict_window(op, x, y, pol);
    if (op == OP_ADVANCE) advances_sent++;
    else events_sent++;
  endtask

  // Coordinates ride along on an advance but must be ignored
  task automatic send_advance();
    send_transaction(OP_ADVANCE, coord_t'($urandom_range(255)),
                     coord_t'($urandom_range(255)), $urandom_range(1) != 0);
  endtask

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, in-order check
  // --------------------------------------------------------------------------

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : check_results
    window_row_t want_row;
    if (rst_n && out_valid && out_ready) begin
      if (pending_rows.size() == 0) begin
        error_count++;
        $display("%0t ns: window row %0d arrived with nothing outstanding", $time,
                 out_window_row);
      end else begin
        want_row = pending_rows.pop_front();
        check_field("ref_pixel", want_row.ref_pixel, out_ref_pixel);
        check_field("tag_pixel", want_row.tag_pixel, out_tag_pixel);
        check_field("window_row", want_row.window_row, out_window_row);
        check_field("event_word", want_row.event_word, out_event_word);
        check_field("last", want_row.last, out_last);
        rows_checked++;
      end
    end
  end

  // Watchdog: ends the run if no transaction moves on either side for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no transaction for %0d cycles, %0d rows outstanding", $time,
               quiet_cycles, pending_rows.size());
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Store corners, coordinates off the store and both kinds of window wrap.
  // Starts from active slice 0 straight after reset.
  task automatic test_window_edges();
    send_transaction(OP_EVENT, 8'd0, 8'd0, 1'b0);        // start wraps to 248
    send_transaction(OP_EVENT, coord_t'(COLUMNS - 1), coord_t'(ROWS - 1), 1'b1);
    send_transaction(OP_EVENT, 8'd255, 8'd255, 1'b1);    // both off the store
    send_transaction(OP_EVENT, coord_t'(COLUMNS), 8'd10, 1'b0);   // column off the store
    send_transaction(OP_EVENT, 8'd20, coord_t'(ROWS), 1'b1);      // row off, window still read
    send_transaction(OP_EVENT, 8'd20, 8'd7, 1'b0);       // start wraps to 255
    send_transaction(OP_EVENT, 8'd20, 8'd8, 1'b1);       // start exactly row 0
    send_transaction(OP_EVENT, 8'd20, 8'd12, 1'b0);
    send_transaction(OP_EVENT, 8'd20, 8'd12, 1'b0);
    send_advance();
    send_advance();
    // slice 0 is now the target: rows 7, 8 and 12 of column 20 show up
    send_transaction(OP_EVENT, 8'd20, 8'd12, 1'b1);
    // past column top
    send_transaction(OP_EVENT, coord_t'(COLUMNS - 1), coord_t'(ROWS - 3), 1'b0);
  endtask

  // Reference and target rotation, and the stale-word clear in slice active+3
  task automatic test_slice_rotation();
    send_advance();                                      // slice 0 is reference, slice 2 stale
    send_transaction(OP_EVENT, 8'd20, 8'd10, 1'b0);      // wipes the row 12 count in slice 2
    send_transaction(OP_EVENT, 8'd0, 8'd3, 1'b1);
    send_advance();                                      // slice 2 is target: must read zero
    send_transaction(OP_EVENT, 8'd20, 8'd12, 1'b0);
    send_advance();
    send_advance();
    send_advance();                                      // slice 0 is reference again
    send_transaction(OP_EVENT, 8'd20, 8'd12, 1'b1);
  endtask

  // Well-formed traffic: bursts of events around a hot spot, then an advance.
  // Single-pixel bursts run the 4-bit counts past 15; reuse of a few columns
  // makes later windows read what earlier slices accumulated.
  task automatic test_hotspot_bursts(int n_items);
    int     sent;
    int     burst_len;
    bit     one_pixel;
    coord_t hot_x;
    coord_t hot_y;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(2))
        0: hot_x = 8'd17;
        1: hot_x = 8'd130;
        default: hot_x = coord_t'(COLUMNS - 1);
      endcase
      if ($urandom_range(4) == 0) hot_y = coord_t'($urandom_range(255));
      else hot_y = coord_t'(96 + $urandom_range(12));
      one_pixel = ($urandom_range(3) == 0);
      burst_len = one_pixel ? $urandom_range(16, 20) : $urandom_range(1, 6);
      for (int i = 0; i < burst_len; i++) begin
        send_transaction(OP_EVENT, hot_x,
                         one_pixel ? hot_y : coord_t'(hot_y + $urandom_range(8)),
                         $urandom_range(1) != 0);
      end
      send_advance();
      sent += burst_len + 1;
    end
  endtask

  // Unstructured traffic over the full coordinate range
  task automatic test_random_noise(int n_items);
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(3) == 0) send_advance();
      else send_transaction(OP_EVENT, coord_t'($urandom_range(255)),
                            coord_t'($urandom_range(255)), $urandom_range(1) != 0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_opcode   = OP_EVENT;
    in_event_x  = '0;
    in_event_y  = '0;
    in_polarity = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Sender sparse-ish, receiver stalling most of the time
    send_idle_pct = 33;
    recv_idle_pct = 62;
    test_window_edges();
    test_slice_rotation();
    test_hotspot_bursts(18);
    test_random_noise(5);

    // Roles swapped: sender gaps dominate
    send_idle_pct = 62;
    recv_idle_pct = 33;
    test_hotspot_bursts(18);
    test_random_noise(5);

    // Full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_hotspot_bursts(18);
    test_random_noise(10);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d event and %0d advance transactions over three pacing phases;",
             events_sent, advances_sent);
    $display("%0d window rows checked across store corners, off-store coordinates,",
             rows_checked);
    $display("wrapped windows and %0d count wrap-arounds.", count_wraps);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/esar_pkg.sv
rtl/esar_ram.sv
rtl/event_slice_accumulate_and_read_top.sv
rtl/esar_checker.sv
tb/sv/event_slice_accumulate_and_read_top_tb.sv
